[design/interpolation_kernel_unit_defines.svh]
// Assertion macros shared by the interpolation kernel unit.
`ifndef INTERPOLATION_KERNEL_UNIT_DEFINES_SVH
`define INTERPOLATION_KERNEL_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge, ignored while reset is high.
`define IKU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
// Check a property on every rising edge, including reset cycles.
`define IKU_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");
`else
`define IKU_ASSERT(lbl, clk, rst, prop)
`define IKU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[design/ikern_pkg.sv]
package ikern_pkg;

   // Pipeline depth: abs/segment, square, cube, polynomial, magnitude, scale
   localparam int NUM_STAGES = 6;

   // Datapath widths
   localparam int A_W   = 14;   // |x| inside the kernel support
   localparam int A2_W  = 28;
   localparam int A3_W  = 42;
   localparam int ACC_W = 48;   // polynomial numerator, scaled by 3 * 2^40
   localparam int T_W   = 17;   // numerator over 2^26, before the divide by 3
   localparam int Q_W   = 15;   // rounded magnitude, at most 1.0 in Q2.14

   // Kernel select codes
   localparam logic FUNC_CUBIC = 1'b0;
   localparam logic FUNC_QUAD  = 1'b1;

   // Piece of the kernel that an offset falls in
   typedef logic [2:0] seg_type;
   localparam seg_type SEG_ZERO = 3'd0;
   localparam seg_type SEG_C0   = 3'd1;   // cubic, a < 1
   localparam seg_type SEG_C1   = 3'd2;   // cubic, 1 <= a < 2
   localparam seg_type SEG_Q0   = 3'd3;   // quadratic, a < 1/2
   localparam seg_type SEG_Q1   = 3'd4;   // quadratic, 1/2 <= a < 3/2

   // Breakpoints in Q2.13
   localparam logic [15:0] BRK_HALF       = 16'd4096;
   localparam logic [15:0] BRK_ONE        = 16'd8192;
   localparam logic [15:0] BRK_THREE_HALF = 16'd12288;
   localparam logic [15:0] BRK_TWO        = 16'd16384;

   // Polynomial constant terms, scaled by 3 * 2^40
   localparam logic signed [ACC_W-1:0] K_2P41    = 48'sh0200_0000_0000;
   localparam logic signed [ACC_W-1:0] K_2P42    = 48'sh0400_0000_0000;
   localparam logic signed [ACC_W-1:0] K_3X2P41  = 48'sh0600_0000_0000;
   localparam logic signed [ACC_W-1:0] K_9X2P38  = 48'sh0240_0000_0000;
   localparam logic signed [ACC_W-1:0] K_27X2P37 = 48'sh0360_0000_0000;
   localparam logic signed [ACC_W-1:0] K_9X2P39  = 48'sh0480_0000_0000;

   // Rounding: q = floor((|n| + 3*2^25) / 2^26 / 3)
   localparam logic [ACC_W-1:0] ROUND_BIAS  = 48'h0000_0600_0000;
   localparam int               SCALE_SHIFT = 26;
   localparam logic [15:0]      RECIP3      = 16'hAAAB;
   localparam int               RECIP_SHIFT = 17;

   typedef struct packed {
      logic signed [15:0] x;
      logic               func;
   } req_type;

   typedef struct packed {
      logic signed [15:0] weight;
      logic signed [15:0] slope;
   } rsp_type;

   typedef struct packed {
      seg_type         seg;
      logic            neg;
      logic [A_W-1:0]  a;
      logic [A2_W-1:0] a2;
      logic [A3_W-1:0] a3;
   } front_type;

   typedef struct packed {
      logic                    neg;
      logic signed [ACC_W-1:0] wn;
      logic signed [ACC_W-1:0] sn;
   } poly_type;

endpackage

[design/interpolation_kernel_unit.sv]
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_ready    req_data : x (Q2.13), func
// rsp       out        rsp_valid / rsp_ready    rsp_data : weight, slope (Q2.14)
//
// One item per cycle sustained while rsp_ready is high; six register stages
// (abs, square, cube, polynomial, magnitude, scale). An accepted item passes
// through all six in order before rsp_valid rises and the result can be taken.
// Every stage has its own valid bit and loads when it is empty or its
// successor moves, so a stall at rsp fills bubbles before it blocks req.
// Reset clears the valid bits only; no clearing pass is needed.
`include "interpolation_kernel_unit_defines.svh"

module interpolation_kernel_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ikern_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ikern_pkg::rsp_type rsp_data
);
   import ikern_pkg::*;

   logic [NUM_STAGES-1:0] valid_in, valid_ff;
   logic [NUM_STAGES-1:0] en;
   front_type             front;
   poly_type              poly;
   logic                  tail_busy;
   logic                  weight_ok, slope_ok;

   // Advance a stage when it is empty or the next one advances
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   // Move valid bits with the data, hold them on a stall
   always_comb begin
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   ikern_power u_power (
      .clock (clock),
      .en    (en[2:0]),
      .req   (req_data),
      .front (front)
   );

   ikern_poly u_poly (
      .clock (clock),
      .en    (en[3]),
      .front (front),
      .poly  (poly)
   );

   ikern_round u_round (
      .clock (clock),
      .en    (en[5:4]),
      .poly  (poly),
      .rsp   (rsp_data)
   );

   // Last two stages both occupied; kernel values inside [-1, 1]
   assign tail_busy = &valid_ff[NUM_STAGES-1 -: 2];
   assign weight_ok = (rsp_data.weight <= 16'sd16384) && (rsp_data.weight >= -16'sd16384);
   assign slope_ok  = (rsp_data.slope <= 16'sd16384) && (rsp_data.slope >= -16'sd16384);

   // An accepted item lands in the first stage
   `IKU_ASSERT(a_accept_enters, clock, reset, (req_valid && req_ready) |=> valid_ff[0])
   // A stall at the output keeps the item queued behind it
   `IKU_ASSERT(a_stall_keeps, clock, reset, (tail_busy && !rsp_ready) |=> tail_busy)
   // Kernel values never leave [-1, 1]
   `IKU_ASSERT(a_range, clock, reset, rsp_valid |-> (weight_ok && slope_ok))
   // Reset empties the pipeline
   `IKU_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (valid_ff == '0))

endmodule

[design/ikern_power.sv]
module ikern_power (
   input  logic                clock,
   input  logic [2:0]          en,
   input  ikern_pkg::req_type  req,
   output ikern_pkg::front_type front
);
   import ikern_pkg::*;

   logic [15:0]     mag;
   seg_type         s1_seg_in;
   seg_type         s1_seg_ff, s2_seg_ff, s3_seg_ff;
   logic            s1_neg_ff, s2_neg_ff, s3_neg_ff;
   logic [A_W-1:0]  s1_a_ff, s2_a_ff, s3_a_ff;
   logic [A2_W-1:0] s2_a2_in, s2_a2_ff, s3_a2_ff;
   logic [A3_W-1:0] s3_a3_in, s3_a3_ff;

   // Take the magnitude; the most negative offset maps to 4.0, out of range
   assign mag = req.x[15] ? (~unsigned'(req.x) + 16'd1) : unsigned'(req.x);

   // Pick the kernel piece from the breakpoints
   always_comb begin
      if (req.func == FUNC_CUBIC) begin
         priority if (mag < BRK_ONE)  s1_seg_in = SEG_C0;
         else if (mag < BRK_TWO)      s1_seg_in = SEG_C1;
         else                         s1_seg_in = SEG_ZERO;
      end else begin
         priority if (mag < BRK_HALF)      s1_seg_in = SEG_Q0;
         else if (mag < BRK_THREE_HALF)    s1_seg_in = SEG_Q1;
         else                              s1_seg_in = SEG_ZERO;
      end
   end

   // Square and cube
   assign s2_a2_in = A2_W'(s1_a_ff) * A2_W'(s1_a_ff);
   assign s3_a3_in = A3_W'(s2_a2_ff) * A3_W'(s2_a_ff);

   // Stage 1: magnitude and segment
   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_seg_ff <= s1_seg_in;
         s1_neg_ff <= req.x[15];
         s1_a_ff   <= mag[A_W-1:0];
      end
   end

   // Stage 2: a^2
   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_seg_ff <= s1_seg_ff;
         s2_neg_ff <= s1_neg_ff;
         s2_a_ff   <= s1_a_ff;
         s2_a2_ff  <= s2_a2_in;
      end
   end

   // Stage 3: a^3
   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_seg_ff <= s2_seg_ff;
         s3_neg_ff <= s2_neg_ff;
         s3_a_ff   <= s2_a_ff;
         s3_a2_ff  <= s2_a2_ff;
         s3_a3_ff  <= s3_a3_in;
      end
   end

   assign front.seg = s3_seg_ff;
   assign front.neg = s3_neg_ff;
   assign front.a   = s3_a_ff;
   assign front.a2  = s3_a2_ff;
   assign front.a3  = s3_a3_ff;

endmodule

[design/ikern_poly.sv]
module ikern_poly (
   input  logic                 clock,
   input  logic                 en,
   input  ikern_pkg::front_type front,
   output ikern_pkg::poly_type  poly
);
   import ikern_pkg::*;

   logic signed [ACC_W-1:0] a_s, a2_s, a3_s;
   logic signed [ACC_W-1:0] wn_in, sn_in;
   logic signed [ACC_W-1:0] wn_ff, sn_ff;
   logic                    neg_ff;

   assign a_s  = signed'(ACC_W'(front.a));
   assign a2_s = signed'(ACC_W'(front.a2));
   assign a3_s = signed'(ACC_W'(front.a3));

   // Form the weight and slope numerators for the selected piece
   always_comb begin
      unique case (front.seg)
         SEG_C0: begin
            wn_in = 48'sd3 * a3_s - 48'sd3 * (a2_s <<< 14) + K_2P41;
            sn_in = 48'sd9 * (a2_s <<< 13) - 48'sd3 * (a_s <<< 28);
         end
         SEG_C1: begin
            wn_in = K_2P42 - a3_s + 48'sd3 * (a2_s <<< 14) - 48'sd3 * (a_s <<< 28);
            sn_in = 48'sd3 * (a_s <<< 28) - 48'sd3 * (a2_s <<< 13) - K_3X2P41;
         end
         SEG_Q0: begin
            wn_in = K_9X2P38 - 48'sd3 * (a2_s <<< 14);
            sn_in = -(48'sd3 * (a_s <<< 28));
         end
         SEG_Q1: begin
            wn_in = 48'sd3 * (a2_s <<< 13) - 48'sd9 * (a_s <<< 26) + K_27X2P37;
            sn_in = 48'sd3 * (a_s <<< 27) - K_9X2P39;
         end
         default: begin
            wn_in = '0;
            sn_in = '0;
         end
      endcase
   end

   // Stage 4: numerators
   always_ff @(posedge clock) begin
      if (en) begin
         wn_ff  <= wn_in;
         sn_ff  <= sn_in;
         neg_ff <= front.neg;
      end
   end

   assign poly.neg = neg_ff;
   assign poly.wn  = wn_ff;
   assign poly.sn  = sn_ff;

endmodule

[design/ikern_round.sv]
module ikern_round (
   input  logic                clock,
   input  logic [1:0]          en,
   input  ikern_pkg::poly_type poly,
   output ikern_pkg::rsp_type  rsp
);
   import ikern_pkg::*;

   logic [ACC_W-1:0]      wmag, smag, wsum, ssum;
   logic [T_W-1:0]        tw_ff, ts_ff;
   logic                  wneg_ff, sneg_ff;
   logic [T_W+15:0]       wprod, sprod;
   logic [Q_W-1:0]        wq, sq;
   logic signed [15:0]    weight_in, slope_in;
   logic signed [15:0]    weight_ff, slope_ff;

   // Magnitude plus half of the scale, then drop the power-of-two part
   assign wmag = poly.wn[ACC_W-1] ? (~unsigned'(poly.wn) + 1'b1) : unsigned'(poly.wn);
   assign smag = poly.sn[ACC_W-1] ? (~unsigned'(poly.sn) + 1'b1) : unsigned'(poly.sn);
   assign wsum = wmag + ROUND_BIAS;
   assign ssum = smag + ROUND_BIAS;

   // Stage 5: scaled magnitudes and signs; the slope takes the sign of x
   always_ff @(posedge clock) begin
      if (en[0]) begin
         tw_ff   <= wsum[SCALE_SHIFT +: T_W];
         ts_ff   <= ssum[SCALE_SHIFT +: T_W];
         wneg_ff <= poly.wn[ACC_W-1];
         sneg_ff <= poly.sn[ACC_W-1] ^ poly.neg;
      end
   end

   // Divide by three through the reciprocal, then restore the sign
   assign wprod     = (T_W+16)'(tw_ff) * (T_W+16)'(RECIP3);
   assign sprod     = (T_W+16)'(ts_ff) * (T_W+16)'(RECIP3);
   assign wq        = wprod[RECIP_SHIFT +: Q_W];
   assign sq        = sprod[RECIP_SHIFT +: Q_W];
   assign weight_in = wneg_ff ? -signed'({1'b0, wq}) : signed'({1'b0, wq});
   assign slope_in  = sneg_ff ? -signed'({1'b0, sq}) : signed'({1'b0, sq});

   // Stage 6: output register
   always_ff @(posedge clock) begin
      if (en[1]) begin
         weight_ff <= weight_in;
         slope_ff  <= slope_in;
      end
   end

   assign rsp.weight = weight_ff;
   assign rsp.slope  = slope_ff;

endmodule
